// ===== rtl/core/tilt_pkg.sv =====
// Shared types and constants for the accelerometer tilt-angle unit.
// Depends on nothing; imported by accel_tilt_angles_unit.
package tilt_pkg;

    // Beat layout on the two stream channels.
    localparam int SAMPLE_W  = 16;
    localparam int ROLL_W    = 16;
    localparam int PITCH_W   = 15;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 32;

    // Datapath widths. Operands carry 20 fraction bits; the angle
    // accumulator counts 2^-20 degree.
    localparam int FRAC_SHIFT   = 20;
    localparam int VEC_W        = 38;
    localparam int ACC_W        = 30;
    localparam int SQ_W         = 31;
    localparam int R2_W         = 32;
    localparam int R2_PAIRS     = R2_W / 2;
    localparam int ROOT_W       = 32;
    localparam int REM_W        = 32;
    localparam int SQRT_STEPS   = 32;
    localparam int RADIUS_SHIFT = 4;
    localparam int ATAN_LEN     = 24;
    localparam int OUT_SHIFT    = 13;

    localparam logic signed [ACC_W-1:0] ANGLE_180   = 30'sd188743680;
    localparam logic signed [ACC_W-1:0] ROUND_BIAS  = 30'sd4096;
    localparam logic signed [ACC_W-1:0] ROLL_LIMIT  = 30'sd23040;
    localparam logic signed [ACC_W-1:0] PITCH_LIMIT = 30'sd11520;

    // One input sample; x sits in the lowest bits of tdata.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] z;
        logic signed [SAMPLE_W-1:0] y;
        logic signed [SAMPLE_W-1:0] x;
    } t_sample;

    // Cases whose angle is fixed and bypasses the CORDIC result.
    typedef struct packed {
        logic roll_fix;    // y is zero
        logic roll_half;   // z is negative
        logic pitch_fix;   // x is zero, or y and z are both zero
        logic pitch_zero;  // x is zero
        logic pitch_up;    // x is negative
    } t_fix;

    // atan(2^-i) in 2^-20 degree, rounded to nearest.
    function automatic logic signed [ACC_W-1:0] atan_entry(input int unsigned idx);
        logic signed [ACC_W-1:0] val;
        unique case (idx)
            0:       val = 30'sd47185920;
            1:       val = 30'sd27855475;
            2:       val = 30'sd14718068;
            3:       val = 30'sd7471121;
            4:       val = 30'sd3750058;
            5:       val = 30'sd1876857;
            6:       val = 30'sd938658;
            7:       val = 30'sd469357;
            8:       val = 30'sd234682;
            9:       val = 30'sd117342;
            10:      val = 30'sd58671;
            11:      val = 30'sd29335;
            12:      val = 30'sd14668;
            13:      val = 30'sd7334;
            14:      val = 30'sd3667;
            15:      val = 30'sd1833;
            16:      val = 30'sd917;
            17:      val = 30'sd458;
            18:      val = 30'sd229;
            19:      val = 30'sd115;
            20:      val = 30'sd57;
            21:      val = 30'sd29;
            22:      val = 30'sd14;
            23:      val = 30'sd7;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/core/accel_tilt_angles_unit.sv =====
// Roll and pitch tilt angles from three-axis accelerometer samples.
// Depends on tilt_pkg (types, widths, arctangent table).
//
// Usage:
//   Slave channel s_axis_*: one beat per sample, tdata = {z, y, x}, signed
//   16-bit raw counts with x in the low bits.
//   Master channel m_axis_*: one beat per sample, tdata = {0, pitch, roll},
//   roll in bits 15:0 and pitch in bits 30:16, both in 1/128 degree.
//   Roll = atan2(y, z) covers -180..+180 degrees, pitch =
//   atan2(-x, sqrt(y*y + z*z)) covers -90..+90 degrees.
//   N is CORDIC_STAGES capped at 24. The path is one input register, two
//   square-and-sum stages, 32 stages of a bit-per-stage square root, one
//   operand setup stage, N CORDIC micro-rotation stages for both angles
//   side by side, and a rounding and saturation stage.
//   Throughput: one beat per cycle while the receiver takes results.
//   Reset clears only the stage valid bits; the payload keeps its value.
//   When the receiver stalls, each stage holds while the one after it is
//   full and held, empty stages keep filling, and s_axis_tready drops
//   only once every stage holds a sample.
module accel_tilt_angles_unit #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // accel_x [15:0], accel_y [31:16], accel_z [47:32]
    input  logic [tilt_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // roll_angle [15:0], pitch_angle [30:16], zero [31]
    output logic [tilt_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
    import tilt_pkg::*;

    localparam int N_STG    = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
    localparam int ST_SQ0   = 3;
    localparam int ST_PREP  = ST_SQ0 + SQRT_STEPS;
    localparam int ST_OUT   = ST_PREP + N_STG + 1;
    localparam int NUM_ST   = ST_OUT + 1;
    localparam int EXT_W    = VEC_W - SAMPLE_W;
    localparam int RAD_PAD  = VEC_W - ROOT_W - RADIUS_SHIFT;
    localparam int OUT_PAD  = M_TDATA_W - ROLL_W - PITCH_W;

    // Stage control.
    logic [NUM_ST-1:0] r_vld;
    logic [NUM_ST-1:0] n_vld;
    logic [NUM_ST-1:0] stage_en;

    // Payload registers, one entry per stage.
    t_sample                  r_xyz    [ST_PREP];
    logic [SQ_W-1:0]          r_ysq;
    logic [SQ_W-1:0]          r_zsq;
    logic [R2_W-1:0]          r_r2;
    logic [R2_W-1:0]          r_sq_r2  [R2_PAIRS-1];
    logic [REM_W-1:0]         r_sq_rem [SQRT_STEPS-1];
    logic [ROOT_W-1:0]        r_sq_q   [SQRT_STEPS];
    logic signed [VEC_W-1:0]  r_rx     [N_STG+1];
    logic signed [VEC_W-1:0]  r_ry     [N_STG+1];
    logic signed [ACC_W-1:0]  r_ra     [N_STG+1];
    logic signed [VEC_W-1:0]  r_px     [N_STG+1];
    logic signed [VEC_W-1:0]  r_py     [N_STG+1];
    logic signed [ACC_W-1:0]  r_pa     [N_STG+1];
    t_fix                     r_fix    [N_STG+1];
    logic [ROLL_W-1:0]        r_out_roll;
    logic [PITCH_W-1:0]       r_out_pitch;

    // Operand setup.
    t_sample                  p_s;
    logic signed [VEC_W-1:0]  p_x;
    logic signed [VEC_W-1:0]  p_y;
    logic signed [VEC_W-1:0]  p_z;
    logic                     p_yz_zero;
    logic signed [VEC_W-1:0]  n_rx;
    logic signed [VEC_W-1:0]  n_ry;
    logic signed [ACC_W-1:0]  n_ra;
    logic signed [VEC_W-1:0]  n_px;
    logic signed [VEC_W-1:0]  n_py;
    t_fix                     n_fix;

    // Output rounding.
    logic signed [ACC_W-1:0]  roll_rnd;
    logic signed [ACC_W-1:0]  pitch_rnd;
    logic signed [ACC_W-1:0]  n_roll;
    logic signed [ACC_W-1:0]  n_pitch;

    logic in_beat;
    logic out_beat;

    // A stage may load when it is empty or its contents move on.
    always_comb begin
        stage_en[NUM_ST-1] = !r_vld[NUM_ST-1] || m_axis_tready;
        for (int k = NUM_ST - 2; k >= 0; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
    end

    assign n_vld = (stage_en & {r_vld[NUM_ST-2:0], s_axis_tvalid}) | (~stage_en & r_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign s_axis_tready = stage_en[0];
    assign m_axis_tvalid = r_vld[NUM_ST-1];
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_beat      = m_axis_tvalid && m_axis_tready;

    // Sample carry up to operand setup.
    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            r_xyz[0] <= t_sample'(s_axis_tdata);
        end
    end

    for (genvar k = 1; k < ST_PREP; k++) begin : g_carry
        always_ff @(posedge i_clk) begin
            if (stage_en[k]) begin
                r_xyz[k] <= r_xyz[k-1];
            end
        end
    end

    // y*y and z*z, then their sum.
    always_ff @(posedge i_clk) begin
        if (stage_en[1]) begin
            r_ysq <= SQ_W'(r_xyz[0].y * r_xyz[0].y);
            r_zsq <= SQ_W'(r_xyz[0].z * r_xyz[0].z);
        end
        if (stage_en[2]) begin
            r_r2 <= R2_W'(r_ysq) + R2_W'(r_zsq);
        end
    end

    // Square root of r2 * 2^32, one root bit per stage. The radicand's
    // low half is zero, so later stages shift in zero bit pairs.
    for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_sqrt
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] q_in;
        logic [1:0]        pair;
        logic [REM_W+1:0]  rem_sh;
        logic [REM_W+1:0]  trial;
        logic [REM_W+1:0]  rem_sub;
        logic              ge;

        if (s == 0) begin : g_first
            assign rem_in = '0;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = r_sq_rem[s-1];
            assign q_in   = r_sq_q[s-1];
        end

        if (s < R2_PAIRS) begin : g_bits
            logic [R2_W-1:0] r2_in;
            if (s == 0) begin : g_src0
                assign r2_in = r_r2;
            end else begin : g_srcn
                assign r2_in = r_sq_r2[s-1];
            end
            assign pair = r2_in[R2_W-1-2*s -: 2];
            if (s < R2_PAIRS - 1) begin : g_keep
                always_ff @(posedge i_clk) begin
                    if (stage_en[ST_SQ0+s]) begin
                        r_sq_r2[s] <= r2_in;
                    end
                end
            end
        end else begin : g_zero
            assign pair = 2'b00;
        end

        assign rem_sh  = {rem_in, pair};
        assign trial   = {q_in, 2'b01};
        assign ge      = (rem_sh >= trial);
        assign rem_sub = rem_sh - trial;

        always_ff @(posedge i_clk) begin
            if (stage_en[ST_SQ0+s]) begin
                r_sq_q[s] <= {q_in[ROOT_W-2:0], ge};
            end
        end

        if (s < SQRT_STEPS - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (stage_en[ST_SQ0+s]) begin
                    r_sq_rem[s] <= ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
                end
            end
        end
    end

    // Operand setup. With z negative the roll vector is turned by half
    // a revolution first, and the accumulator starts at +-180 degrees.
    always_comb begin
        p_s       = r_xyz[ST_PREP-1];
        p_x       = {{EXT_W{p_s.x[SAMPLE_W-1]}}, p_s.x};
        p_y       = {{EXT_W{p_s.y[SAMPLE_W-1]}}, p_s.y};
        p_z       = {{EXT_W{p_s.z[SAMPLE_W-1]}}, p_s.z};
        p_yz_zero = (p_s.y == '0) && (p_s.z == '0);

        if (p_s.z[SAMPLE_W-1]) begin
            n_rx = (-p_z) <<< FRAC_SHIFT;
            n_ry = (-p_y) <<< FRAC_SHIFT;
            n_ra = p_s.y[SAMPLE_W-1] ? -ANGLE_180 : ANGLE_180;
        end else begin
            n_rx = p_z <<< FRAC_SHIFT;
            n_ry = p_y <<< FRAC_SHIFT;
            n_ra = '0;
        end

        n_px = $signed({{RAD_PAD{1'b0}}, r_sq_q[SQRT_STEPS-1], {RADIUS_SHIFT{1'b0}}});
        n_py = (-p_x) <<< FRAC_SHIFT;

        n_fix.roll_fix   = (p_s.y == '0);
        n_fix.roll_half  = p_s.z[SAMPLE_W-1];
        n_fix.pitch_zero = (p_s.x == '0);
        n_fix.pitch_fix  = (p_s.x == '0) || p_yz_zero;
        n_fix.pitch_up   = p_s.x[SAMPLE_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[ST_PREP]) begin
            r_rx[0]  <= n_rx;
            r_ry[0]  <= n_ry;
            r_ra[0]  <= n_ra;
            r_px[0]  <= n_px;
            r_py[0]  <= n_py;
            r_pa[0]  <= '0;
            r_fix[0] <= n_fix;
        end
    end

    // Vectoring CORDIC: each stage turns both vectors toward the x axis
    // and adds the turned angle to its accumulator.
    for (genvar j = 0; j < N_STG; j++) begin : g_cordic
        localparam logic signed [ACC_W-1:0] ANG = atan_entry(j);
        logic signed [VEC_W-1:0] rdx;
        logic signed [VEC_W-1:0] rdy;
        logic signed [VEC_W-1:0] pdx;
        logic signed [VEC_W-1:0] pdy;

        assign rdx = r_ry[j] >>> j;
        assign rdy = r_rx[j] >>> j;
        assign pdx = r_py[j] >>> j;
        assign pdy = r_px[j] >>> j;

        always_ff @(posedge i_clk) begin
            if (stage_en[ST_PREP+1+j]) begin
                if (!r_ry[j][VEC_W-1]) begin
                    r_rx[j+1] <= r_rx[j] + rdx;
                    r_ry[j+1] <= r_ry[j] - rdy;
                    r_ra[j+1] <= r_ra[j] + ANG;
                end else begin
                    r_rx[j+1] <= r_rx[j] - rdx;
                    r_ry[j+1] <= r_ry[j] + rdy;
                    r_ra[j+1] <= r_ra[j] - ANG;
                end
                if (!r_py[j][VEC_W-1]) begin
                    r_px[j+1] <= r_px[j] + pdx;
                    r_py[j+1] <= r_py[j] - pdy;
                    r_pa[j+1] <= r_pa[j] + ANG;
                end else begin
                    r_px[j+1] <= r_px[j] - pdx;
                    r_py[j+1] <= r_py[j] + pdy;
                    r_pa[j+1] <= r_pa[j] - ANG;
                end
                r_fix[j+1] <= r_fix[j];
            end
        end
    end

    // Round to 1/128 degree, half toward plus infinity, then saturate.
    always_comb begin
        roll_rnd  = (r_ra[N_STG] + ROUND_BIAS) >>> OUT_SHIFT;
        pitch_rnd = (r_pa[N_STG] + ROUND_BIAS) >>> OUT_SHIFT;

        priority if (r_fix[N_STG].roll_fix) begin
            n_roll = r_fix[N_STG].roll_half ? ROLL_LIMIT : '0;
        end else if (roll_rnd > ROLL_LIMIT) begin
            n_roll = ROLL_LIMIT;
        end else if (roll_rnd < -ROLL_LIMIT) begin
            n_roll = -ROLL_LIMIT;
        end else begin
            n_roll = roll_rnd;
        end

        priority if (r_fix[N_STG].pitch_fix) begin
            if (r_fix[N_STG].pitch_zero) begin
                n_pitch = '0;
            end else begin
                n_pitch = r_fix[N_STG].pitch_up ? PITCH_LIMIT : -PITCH_LIMIT;
            end
        end else if (pitch_rnd > PITCH_LIMIT) begin
            n_pitch = PITCH_LIMIT;
        end else if (pitch_rnd < -PITCH_LIMIT) begin
            n_pitch = -PITCH_LIMIT;
        end else begin
            n_pitch = pitch_rnd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[ST_OUT]) begin
            r_out_roll  <= n_roll[ROLL_W-1:0];
            r_out_pitch <= n_pitch[PITCH_W-1:0];
        end
    end

    assign m_axis_tdata = {{OUT_PAD{1'b0}}, r_out_pitch, r_out_roll};

    // Reset empties the whole pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // Occupancy changes only by accepted input and delivered output beats.
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
        $countones(r_vld) == $past($countones(r_vld)) + int'($past(in_beat))
                             - int'($past(out_beat)))
        else $error("stage valid bits lost or duplicated a sample");

    // An empty output register means no stage can be blocked.
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while the output register is empty");

    // Delivered angles stay inside their saturation limits.
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
        ($signed(r_out_roll) <= ROLL_LIMIT) && ($signed(r_out_roll) >= -ROLL_LIMIT) &&
        ($signed(r_out_pitch) <= PITCH_LIMIT) && ($signed(r_out_pitch) >= -PITCH_LIMIT))
        else $error("angle outside its saturation range");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for accel_tilt_angles_unit: random bursty samples in,
// stalling receiver out, each roll/pitch beat compared with a local model.
// Depends on tilt_pkg (sample layout) and the unit under test.
module tb_top;

    localparam int  N_STAGES       = 16;
    localparam int  USED_STAGES    = (N_STAGES > 24) ? 24 : N_STAGES;
    localparam longint UNIT        = 64'sd1048576;     // 1.0 at 20 fraction bits
    localparam longint HALF_TURN   = 64'sd188743680;   // 180 degrees at 2^-20
    localparam longint ROLL_MAX    = 64'sd23040;
    localparam longint PITCH_MAX   = 64'sd11520;
    localparam int  RANDOM_SAMPLES = 400;
    localparam int  HOLD_START     = 200;
    localparam int  HOLD_LEN       = 300;
    localparam int  DRAIN_CYCLES   = 120;
    localparam int  TIMEOUT_CYCLES = 200000;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
    } t_tilt;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    tilt_pkg::t_sample  s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [31:0]        m_data;

    tilt_pkg::t_sample  samples_to_send [$];
    t_tilt              pending_tilts [$];
    t_tilt              want_tilt;
    int                 mismatch_count = 0;
    int                 burst_left = 0;
    int                 gap_left = 0;
    int                 rx_cycle = 0;
    int                 run_left = 0;
    logic               ready_run = 1'b1;

    // atan(2^-i) in 2^-20 degree.
    longint atan_step [24] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
        234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7
    };

    accel_tilt_angles_unit #(
        .CORDIC_STAGES(N_STAGES)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data)
    );

    always #5 clk = ~clk;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned rem = v;
        longint unsigned root = 0;
        longint unsigned b = 64'h4000_0000_0000_0000;
        while (b > rem)
            b = b >> 2;
        while (b != 0) begin
            if (rem >= root + b) begin
                rem = rem - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    // Vectoring rotation: turns (px, py) onto the positive x axis and
    // accumulates the angle turned.
    function automatic longint rotate_to_axis(longint px, longint py, longint acc);
        longint dx;
        longint dy;
        for (int i = 0; i < USED_STAGES; i++) begin
            dx = py >>> i;
            dy = px >>> i;
            if (py >= 0) begin
                px = px + dx;
                py = py - dy;
                acc = acc + atan_step[i];
            end else begin
                px = px - dx;
                py = py + dy;
                acc = acc - atan_step[i];
            end
        end
        return acc;
    endfunction

    function automatic longint round_clamp(longint acc, longint lim);
        longint r;
        r = (acc + 64'sd4096) >>> 13;
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return r;
    endfunction

    function automatic t_tilt predict_tilt(tilt_pkg::t_sample s);
        longint          x;
        longint          y;
        longint          z;
        longint          roll;
        longint          pitch;
        longint unsigned r2;
        longint          radius;
        t_tilt           t;
        x = s.x;
        y = s.y;
        z = s.z;
        if (y == 0)
            roll = (z < 0) ? ROLL_MAX : 0;
        else if (z >= 0)
            roll = round_clamp(rotate_to_axis(z * UNIT, y * UNIT, 0), ROLL_MAX);
        else
            // Negative z: turn the vector by a half turn first.
            roll = round_clamp(rotate_to_axis(-z * UNIT, -y * UNIT,
                                              (y > 0) ? HALF_TURN : -HALF_TURN), ROLL_MAX);
        r2 = longint'(y * y + z * z);
        if (x == 0) begin
            pitch = 0;
        end else if (r2 == 0) begin
            pitch = (x < 0) ? PITCH_MAX : -PITCH_MAX;
        end else begin
            radius = longint'(int_sqrt(r2 << 32)) * 16;
            pitch = round_clamp(rotate_to_axis(radius, -x * UNIT, 0), PITCH_MAX);
        end
        t.roll = roll[15:0];
        t.pitch = pitch[14:0];
        return t;
    endfunction

    function automatic logic [15:0] random_count();
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = 16'($urandom_range(0, 65535));
            4, 5:       v = 16'($urandom_range(0, 600) - 300);
            6:          v = '0;
            7: begin
                case ($urandom_range(0, 5))
                    0:       v = 16'h8000;
                    1:       v = 16'h8001;
                    2:       v = 16'hFFFF;
                    3:       v = 16'h0001;
                    4:       v = 16'h7FFF;
                    default: v = 16'h0000;
                endcase
            end
            default:    v = 16'($urandom_range(0, 36000) - 18000);
        endcase
        return v;
    endfunction

    task automatic queue_sample(input int x, input int y, input int z);
        tilt_pkg::t_sample s;
        s.x = 16'(x);
        s.y = 16'(y);
        s.z = 16'(z);
        samples_to_send.push_back(s);
    endtask

    // Sender: bursts of beats with random gaps; a beat that is not yet
    // taken stays on the bus unchanged.
    always @(posedge clk) begin
        if (!rst_n) begin
            s_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                pending_tilts.push_back(predict_tilt(s_data));
                samples_to_send.delete(0);
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (samples_to_send.size() > 0) begin
                    s_valid <= 1'b1;
                    s_data <= samples_to_send[0];
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 30);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random ready and stall runs, plus one long hold that backs
    // the whole pipeline up into the input.
    always @(posedge clk) begin
        if (!rst_n) begin
            m_ready <= 1'b0;
            rx_cycle = 0;
            run_left = 0;
        end else begin
            rx_cycle++;
            if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN) begin
                m_ready <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    ready_run = ($urandom_range(0, 3) != 0);
                    run_left = ready_run ? $urandom_range(1, 40) : $urandom_range(1, 8);
                end
                run_left--;
                m_ready <= ready_run;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_valid && m_ready) begin
            if (pending_tilts.size() == 0) begin
                $error("result beat with no sample outstanding: tdata %h", m_data);
                mismatch_count++;
            end else begin
                want_tilt = pending_tilts.pop_front();
                if (m_data[15:0] !== want_tilt.roll) begin
                    $error("roll_angle: expected %0d, actual %0d",
                           want_tilt.roll, $signed(m_data[15:0]));
                    mismatch_count++;
                end
                if (m_data[30:16] !== want_tilt.pitch) begin
                    $error("pitch_angle: expected %0d, actual %0d",
                           want_tilt.pitch, $signed(m_data[30:16]));
                    mismatch_count++;
                end
                if (m_data[31] !== 1'b0) begin
                    $error("zero pad: expected 0, actual %b", m_data[31]);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        tilt_pkg::t_sample s;
        queue_sample(0, 0, 0);
        queue_sample(0, 0, 16384);
        queue_sample(0, 0, -16384);
        queue_sample(100, 0, -1);
        queue_sample(0, 1000, -1000);
        queue_sample(0, -1000, -1000);
        queue_sample(0, 1, -32768);
        queue_sample(0, -1, -32768);
        queue_sample(16384, 0, 0);
        queue_sample(-16384, 0, 0);
        queue_sample(-32768, 0, 0);
        queue_sample(32767, 0, 0);
        queue_sample(0, 16384, 0);
        queue_sample(0, -16384, 0);
        queue_sample(32767, 32767, 32767);
        queue_sample(-32768, -32768, -32768);
        queue_sample(-32768, 32767, -32768);
        queue_sample(32767, -32768, 32767);
        queue_sample(1, -32768, -32768);
        queue_sample(-1, 32767, -32768);
        queue_sample(12000, -8000, 15000);
        queue_sample(-1, 0, 1);
        for (int n = 0; n < RANDOM_SAMPLES; n++) begin
            s.x = random_count();
            s.y = random_count();
            s.z = random_count();
            samples_to_send.push_back(s);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (samples_to_send.size() != 0 || s_valid)
            @(posedge clk);
        while (pending_tilts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge clk);
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== accel_tilt_angles_unit.f =====
rtl/core/tilt_pkg.sv
rtl/core/accel_tilt_angles_unit.sv
bench/tb_top.sv
